// ===== hdl/lj126wf_pkg.sv =====
// ----------------------------------------------------------------------------
// lj126wf_pkg
// Shared types, constants and helpers for the Lennard-Jones wall force unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lj126wf_pkg;

    localparam int unsigned QW      = 48;
    localparam int unsigned POSW    = 32;
    localparam int unsigned CUTW    = 31;
    localparam int unsigned QUOW    = 41;
    localparam int unsigned DIV_LAT = 41;
    localparam int unsigned MUL_LAT = 3;

    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_WALL_FACE   = 3'd0,
        REG_WALL_POS    = 3'd1,
        REG_CUTOFF      = 3'd2,
        REG_E_OFFSET    = 3'd3,
        REG_F_REP       = 3'd4,
        REG_F_ATT       = 3'd5,
        REG_E_REP       = 3'd6,
        REG_E_ATT       = 3'd7
    } reg_idx_t;

    typedef logic signed [QW-1:0] q_t;

    function automatic q_t sat49(input logic signed [QW:0] v);
        q_t r;
        r = v[QW-1:0];
        if (v[QW] != v[QW-1])
        begin
            r = v[QW] ? QMIN : QMAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lj126wf_dly.sv =====
// ----------------------------------------------------------------------------
// lj126wf_dly
// Clock-enabled delay line of fixed depth.
// ----------------------------------------------------------------------------
`default_nettype none
module lj126wf_dly #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             ce,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (ce)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule
`default_nettype wire

// ===== hdl/lj126wf_div.sv =====
// ----------------------------------------------------------------------------
// lj126wf_div
// Pipelined restoring divider: rinv = (2^40 + d/2) / d, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module lj126wf_div (
    input  wire logic                              clk,
    input  wire logic                              ce,
    input  wire logic [lj126wf_pkg::CUTW-1:0]      d,
    output logic      [lj126wf_pkg::QUOW-1:0]      quo
);

    localparam int unsigned NS = lj126wf_pkg::QUOW;
    localparam int unsigned DW = lj126wf_pkg::CUTW;

    logic [DW-1:0] rem_reg [NS];
    logic [NS-1:0] num_reg [NS];
    logic [NS-1:0] quo_reg [NS];
    logic [DW-1:0] den_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NS-1:0] num_in;
        logic [NS-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = {1'b1, {(NS-1){1'b0}}} + ({{(NS-DW){1'b0}}, d} >> 1);
            assign quo_in = '0;
            assign den_in = d;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign trial = {rem_in, num_in[NS-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (trial >= {1'b0, den_in})
                begin
                    rem_reg[k] <= diff[DW-1:0];
                    quo_reg[k] <= {quo_in[NS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= trial[DW-1:0];
                    quo_reg[k] <= {quo_in[NS-2:0], 1'b0};
                end
                num_reg[k] <= {num_in[NS-2:0], 1'b0};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[NS-1];

endmodule
`default_nettype wire

// ===== hdl/lj126wf_mulq.sv =====
// ----------------------------------------------------------------------------
// lj126wf_mulq
// Three-stage Q24.24 multiplier: magnitudes, 24x24 partial products, then
// sum, round half away from zero and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module lj126wf_mulq (
    input  wire logic              clk,
    input  wire logic              ce,
    input  wire lj126wf_pkg::q_t   a,
    input  wire lj126wf_pkg::q_t   b,
    output lj126wf_pkg::q_t        y
);

    localparam int unsigned QW = lj126wf_pkg::QW;
    localparam int unsigned HW = QW / 2;

    logic          neg1_reg;
    logic [QW-1:0] ua_reg;
    logic [QW-1:0] ub_reg;
    logic          neg2_reg;
    logic [QW-1:0] p_ll_reg;
    logic [QW-1:0] p_lh_reg;
    logic [QW-1:0] p_hl_reg;
    logic [QW-1:0] p_hh_reg;
    lj126wf_pkg::q_t y_reg;

    logic [2*QW-1:0] sum;
    logic [QW+HW-1:0] mag;
    lj126wf_pkg::q_t y_next;

    always_comb
    begin
        sum = {{QW{1'b0}}, p_ll_reg}
            + ({{QW{1'b0}}, p_lh_reg} << HW)
            + ({{QW{1'b0}}, p_hl_reg} << HW)
            + ({{QW{1'b0}}, p_hh_reg} << QW)
            + ({{(2*QW-1){1'b0}}, 1'b1} << (HW-1));
        mag = sum[2*QW-1:HW];
        if (neg2_reg)
        begin
            if (mag > {{HW{1'b0}}, 1'b1, {(QW-1){1'b0}}})
            begin
                y_next = lj126wf_pkg::QMIN;
            end
            else
            begin
                y_next = -mag[QW-1:0];
            end
        end
        else if (mag > {{(HW+1){1'b0}}, {(QW-1){1'b1}}})
        begin
            y_next = lj126wf_pkg::QMAX;
        end
        else
        begin
            y_next = mag[QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg1_reg <= a[QW-1] ^ b[QW-1];
            ua_reg   <= a[QW-1] ? -a : a;
            ub_reg   <= b[QW-1] ? -b : b;
            neg2_reg <= neg1_reg;
            p_ll_reg <= ua_reg[HW-1:0]  * ub_reg[HW-1:0];
            p_lh_reg <= ua_reg[HW-1:0]  * ub_reg[QW-1:HW];
            p_hl_reg <= ua_reg[QW-1:HW] * ub_reg[HW-1:0];
            p_hh_reg <= ua_reg[QW-1:HW] * ub_reg[QW-1:HW];
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule
`default_nettype wire

// ===== hdl/lj126_wall_force_unit.sv =====
// Throughput: one item per cycle while the output is not stalled; set by the
// 41-stage divider and the chain of 3-stage multipliers, all advancing under one clock enable.
// The whole pipeline, bubbles included, holds while the output register waits.
// Reset: rst_n clears all valid bits and configuration registers to zero.
// ----------------------------------------------------------------------------
// lj126_wall_force_unit
// 12-6 Lennard-Jones wall force, energy and virial, one atom per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module lj126_wall_force_unit #(
    parameter int unsigned DIMENSIONS = 3
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [5:0]                paddr,
    input  wire logic [63:0]               pwdata,
    output logic      [63:0]               prdata,
    output logic                           pready,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [32*DIMENSIONS-1:0]  s_tdata,   // pos_x, pos_y[, pos_z]
    input  wire logic                      s_tlast,   // last_atom
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [143:0]              m_tdata,   // force_change, energy_add, virial_add
    output logic                           m_tuser,   // in_range
    output logic                           m_tlast    // last_out
);

    localparam int unsigned QW   = lj126wf_pkg::QW;
    localparam int unsigned ML   = lj126wf_pkg::MUL_LAT;
    localparam int unsigned SBD  = lj126wf_pkg::DIV_LAT + 6*ML + 1;
    localparam int unsigned SBW  = 3 + 32;

    logic [2:0]            face_reg;
    logic signed [31:0]    wall_pos_reg;
    logic [30:0]           cutoff_reg;
    lj126wf_pkg::q_t       e_off_reg;
    lj126wf_pkg::q_t       f_rep_reg;
    lj126wf_pkg::q_t       f_att_reg;
    lj126wf_pkg::q_t       e_rep_reg;
    lj126wf_pkg::q_t       e_att_reg;

    logic                  cfg_wr;
    lj126wf_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = lj126wf_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_reg     <= '0;
            wall_pos_reg <= '0;
            cutoff_reg   <= '0;
            e_off_reg    <= '0;
            f_rep_reg    <= '0;
            f_att_reg    <= '0;
            e_rep_reg    <= '0;
            e_att_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                lj126wf_pkg::REG_WALL_FACE: face_reg     <= pwdata[2:0];
                lj126wf_pkg::REG_WALL_POS:  wall_pos_reg <= pwdata[31:0];
                lj126wf_pkg::REG_CUTOFF:    cutoff_reg   <= pwdata[30:0];
                lj126wf_pkg::REG_E_OFFSET:  e_off_reg    <= pwdata[QW-1:0];
                lj126wf_pkg::REG_F_REP:     f_rep_reg    <= pwdata[QW-1:0];
                lj126wf_pkg::REG_F_ATT:     f_att_reg    <= pwdata[QW-1:0];
                lj126wf_pkg::REG_E_REP:     e_rep_reg    <= pwdata[QW-1:0];
                lj126wf_pkg::REG_E_ATT:     e_att_reg    <= pwdata[QW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            lj126wf_pkg::REG_WALL_FACE: prdata = {61'b0, face_reg};
            lj126wf_pkg::REG_WALL_POS:  prdata = {32'b0, wall_pos_reg};
            lj126wf_pkg::REG_CUTOFF:    prdata = {33'b0, cutoff_reg};
            lj126wf_pkg::REG_E_OFFSET:  prdata = {16'b0, e_off_reg};
            lj126wf_pkg::REG_F_REP:     prdata = {16'b0, f_rep_reg};
            lj126wf_pkg::REG_F_ATT:     prdata = {16'b0, f_att_reg};
            lj126wf_pkg::REG_E_REP:     prdata = {16'b0, e_rep_reg};
            lj126wf_pkg::REG_E_ATT:     prdata = {16'b0, e_att_reg};
            default:                    prdata = '0;
        endcase
    end

    // pipeline enable
    logic ce;
    logic out_valid_reg;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // stage 0: face select and distance
    logic [1:0]         axis;
    logic               face_ok;
    logic signed [31:0] pos;
    logic signed [32:0] delta;
    logic               hit;

    always_comb
    begin
        axis    = face_reg[2:1];
        face_ok = ({30'b0, axis} < DIMENSIONS) && (axis != 2'd3);
        case (axis)
            2'd0:    pos = s_tdata[31:0];
            2'd1:    pos = s_tdata[63:32];
            default: pos = s_tdata[32*DIMENSIONS-1 -: 32];
        endcase
        if (face_reg[0])
        begin
            delta = {wall_pos_reg[31], wall_pos_reg} - {pos[31], pos};
        end
        else
        begin
            delta = {pos[31], pos} - {wall_pos_reg[31], wall_pos_reg};
        end
        hit = face_ok && !delta[32] && (delta != '0) && (delta < {2'b0, cutoff_reg});
    end

    logic        v0_reg;
    logic        hit0_reg;
    logic        up0_reg;
    logic        last0_reg;
    logic [31:0] delta0_reg;
    logic [30:0] d0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (ce)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hit0_reg   <= hit;
            up0_reg    <= face_reg[0];
            last0_reg  <= s_tlast;
            delta0_reg <= delta[31:0];
            d0_reg     <= hit ? delta[30:0] : 31'd1;
        end
    end

    // sideband
    logic [SBW-1:0] sb;
    logic           v_sb;
    logic           hit_sb;
    logic           up_sb;
    logic           last_sb;
    logic [31:0]    delta_sb;
    logic [2:0]     tail;
    logic           v_end;

    lj126wf_dly #(.WIDTH(SBW), .DEPTH(SBD)) u_sb_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .din({hit0_reg, up0_reg, last0_reg, delta0_reg}),
        .dout(sb)
    );
    lj126wf_dly #(.WIDTH(1), .DEPTH(SBD + ML)) u_v_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce), .din(v0_reg), .dout(v_end)
    );
    assign {hit_sb, up_sb, last_sb, delta_sb} = sb;
    assign v_sb = 1'b0;

    lj126wf_dly #(.WIDTH(2), .DEPTH(ML)) u_tail_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .din({hit_sb, last_sb}), .dout(tail[1:0])
    );
    assign tail[2] = v_sb;

    // divider
    logic [lj126wf_pkg::QUOW-1:0] quo;
    lj126wf_pkg::q_t              rinv;

    lj126wf_div u_div (.clk(clk), .ce(ce), .d(d0_reg), .quo(quo));
    assign rinv = {{(QW-lj126wf_pkg::QUOW){1'b0}}, quo};

    // multiply chain
    lj126wf_pkg::q_t r2, r2_d, r4, r6, r6_d, t1, e1, w1, en, en_d, rinv_d, w;
    lj126wf_pkg::q_t t_reg, e_reg, fq_reg, eq_reg, fq_d, eq_d, virial, delta8;

    lj126wf_mulq u_m_r2 (.clk(clk), .ce(ce), .a(rinv), .b(rinv), .y(r2));
    lj126wf_dly #(.WIDTH(QW), .DEPTH(ML)) u_r2_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce), .din(r2), .dout(r2_d)
    );
    lj126wf_mulq u_m_r4 (.clk(clk), .ce(ce), .a(r2), .b(r2), .y(r4));
    lj126wf_mulq u_m_r6 (.clk(clk), .ce(ce), .a(r4), .b(r2_d), .y(r6));
    lj126wf_mulq u_m_t1 (.clk(clk), .ce(ce), .a(f_rep_reg), .b(r6), .y(t1));
    lj126wf_mulq u_m_e1 (.clk(clk), .ce(ce), .a(e_rep_reg), .b(r6), .y(e1));
    lj126wf_dly #(.WIDTH(QW), .DEPTH(ML + 1)) u_r6_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce), .din(r6), .dout(r6_d)
    );

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t_reg <= lj126wf_pkg::sat49({t1[QW-1], t1} - {f_att_reg[QW-1], f_att_reg});
            e_reg <= lj126wf_pkg::sat49({e1[QW-1], e1} - {e_att_reg[QW-1], e_att_reg});
        end
    end

    lj126wf_mulq u_m_w1 (.clk(clk), .ce(ce), .a(r6_d), .b(t_reg), .y(w1));
    lj126wf_mulq u_m_en (.clk(clk), .ce(ce), .a(r6_d), .b(e_reg), .y(en));
    lj126wf_dly #(.WIDTH(QW), .DEPTH(5*ML + 1)) u_rinv_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce), .din(rinv), .dout(rinv_d)
    );
    lj126wf_mulq u_m_w (.clk(clk), .ce(ce), .a(w1), .b(rinv_d), .y(w));
    lj126wf_dly #(.WIDTH(QW), .DEPTH(ML)) u_en_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce), .din(en), .dout(en_d)
    );

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fq_reg <= up_sb ? w : lj126wf_pkg::sat49(-{w[QW-1], w});
            eq_reg <= lj126wf_pkg::sat49({en_d[QW-1], en_d} - {e_off_reg[QW-1], e_off_reg});
        end
    end

    assign delta8 = {8'b0, delta_sb, 8'b0};
    lj126wf_mulq u_m_vir (.clk(clk), .ce(ce), .a(w), .b(delta8), .y(virial));
    lj126wf_dly #(.WIDTH(2*QW), .DEPTH(ML - 1)) u_fe_dly (
        .clk(clk), .rst_n(rst_n), .ce(ce),
        .din({eq_reg, fq_reg}), .dout({eq_d, fq_d})
    );

    // output register
    logic [143:0] data_reg;
    logic         range_reg;
    logic         last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= v_end || tail[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            data_reg  <= tail[1] ? {virial, eq_d, fq_d} : '0;
            range_reg <= tail[1];
            last_reg  <= tail[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = range_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("out-of-range result not zero");

    a_bad_face: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (face_reg == 3'd6 || face_reg == 3'd7) |-> !m_tuser)
        else $error("in_range set with invalid wall face");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(data_reg))
        else $error("result lost under stall");
`endif

endmodule
`default_nettype wire

// ===== verif/lj126_wall_force_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lj126_wall_force_unit_test
// Runs atom positions through the wall force unit under several wall and
// coefficient settings. A scoreboard predicts force change, energy, virial
// and flags per atom, and checks every output transfer in order.
// ----------------------------------------------------------------------------

typedef struct {
    lj126wf_pkg::q_t force_change;
    lj126wf_pkg::q_t energy_add;
    lj126wf_pkg::q_t virial_add;
    logic            in_range;
    logic            last_out;
} wall_result_t;

class wall_force_board;
    int unsigned  dims;
    logic [2:0]   face;
    logic signed [31:0] wall_pos;
    logic [30:0]  cutoff;
    lj126wf_pkg::q_t e_offset, f_rep, f_att, e_rep, e_att;
    wall_result_t pending_results[$];
    int unsigned  errors;

    function new(int unsigned d);
        dims = d;
        face = 0; wall_pos = 0; cutoff = 0;
        e_offset = 0; f_rep = 0; f_att = 0; e_rep = 0; e_att = 0;
        errors = 0;
    endfunction

    function void set_reg(lj126wf_pkg::reg_idx_t idx, logic [63:0] v);
        case (idx)
            lj126wf_pkg::REG_WALL_FACE: face = v[2:0];
            lj126wf_pkg::REG_WALL_POS:  wall_pos = v[31:0];
            lj126wf_pkg::REG_CUTOFF:    cutoff = v[30:0];
            lj126wf_pkg::REG_E_OFFSET:  e_offset = v[47:0];
            lj126wf_pkg::REG_F_REP:     f_rep = v[47:0];
            lj126wf_pkg::REG_F_ATT:     f_att = v[47:0];
            lj126wf_pkg::REG_E_REP:     e_rep = v[47:0];
            lj126wf_pkg::REG_E_ATT:     e_att = v[47:0];
            default: ;
        endcase
    endfunction

    function lj126wf_pkg::q_t clamp(longint v);
        if (v > longint'(lj126wf_pkg::QMAX)) return lj126wf_pkg::QMAX;
        if (v < longint'(lj126wf_pkg::QMIN)) return lj126wf_pkg::QMIN;
        return lj126wf_pkg::q_t'(v);
    endfunction

    // Q24.24 product, magnitude rounded half away from zero, saturated
    function lj126wf_pkg::q_t qmul(lj126wf_pkg::q_t a, lj126wf_pkg::q_t b);
        logic [47:0] ma, mb;
        logic [95:0] p;
        logic        neg;
        neg = a[47] ^ b[47];
        ma = a[47] ? -a : a;
        mb = b[47] ? -b : b;
        p = ({48'd0, ma} * {48'd0, mb} + 96'd8388608) >> 24;
        if (neg)
        begin
            if (p > 96'h800000000000) return lj126wf_pkg::QMIN;
            return lj126wf_pkg::q_t'(-p[47:0]);
        end
        if (p > 96'h7FFFFFFFFFFF) return lj126wf_pkg::QMAX;
        return lj126wf_pkg::q_t'(p[47:0]);
    endfunction

    function void note_atom(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic last);
        wall_result_t r;
        int unsigned  axis;
        longint       pos, delta, rinv;
        lj126wf_pkg::q_t r2, r6, t, w, e;
        axis = face >> 1;
        r.force_change = 0; r.energy_add = 0; r.virial_add = 0;
        r.in_range = 0; r.last_out = last;
        if (axis < 3 && axis < dims)
        begin
            pos = (axis == 0) ? px : (axis == 1) ? py : pz;
            delta = face[0] ? longint'(wall_pos) - pos : pos - longint'(wall_pos);
            if (delta > 0 && delta < longint'({1'b0, cutoff}))
            begin
                rinv = ((64'd1 << 40) + (delta >> 1)) / delta;
                r2 = qmul(lj126wf_pkg::q_t'(rinv), lj126wf_pkg::q_t'(rinv));
                r6 = qmul(qmul(r2, r2), r2);
                t = clamp(longint'(qmul(f_rep, r6)) - longint'(f_att));
                w = qmul(qmul(r6, t), lj126wf_pkg::q_t'(rinv));
                e = clamp(longint'(qmul(e_rep, r6)) - longint'(e_att));
                r.force_change = face[0] ? w : clamp(-longint'(w));
                r.energy_add = clamp(longint'(qmul(r6, e)) - longint'(e_offset));
                r.virial_add = qmul(w, lj126wf_pkg::q_t'(delta * 256));
                r.in_range = 1;
            end
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [143:0] data, logic flag, logic last);
        wall_result_t x;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result data=%h", $time, data);
            errors++;
            return;
        end
        x = pending_results.pop_front();
        if (data[47:0] !== x.force_change)
        begin
            $display("%0t: force_change exp %h act %h", $time, x.force_change, data[47:0]);
            errors++;
        end
        if (data[95:48] !== x.energy_add)
        begin
            $display("%0t: energy_add exp %h act %h", $time, x.energy_add, data[95:48]);
            errors++;
        end
        if (data[143:96] !== x.virial_add)
        begin
            $display("%0t: virial_add exp %h act %h", $time, x.virial_add, data[143:96]);
            errors++;
        end
        if (flag !== x.in_range)
        begin
            $display("%0t: in_range exp %b act %b", $time, x.in_range, flag);
            errors++;
        end
        if (last !== x.last_out)
        begin
            $display("%0t: last_out exp %b act %b", $time, x.last_out, last);
            errors++;
        end
    endfunction
endclass

module lj126_wall_force_unit_test;
    localparam int unsigned DIMS = 3;
    localparam int unsigned STALL_LIMIT = 3000;

    logic          clk = 0;
    logic          rst_n = 0;
    logic          psel = 0, penable = 0, pwrite = 0;
    logic [5:0]    paddr = 0;
    logic [63:0]   pwdata = 0;
    logic [63:0]   prdata;
    logic          pready;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [32*DIMS-1:0] s_tdata = 0;   // pos_x, pos_y, pos_z
    logic          s_tlast = 0;        // last_atom
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [143:0]  m_tdata;            // force_change, energy_add, virial_add
    logic          m_tuser;            // in_range
    logic          m_tlast;            // last_out

    wall_force_board board = new(DIMS);
    bit            no_idle = 0;
    bit            hold_req = 0;
    int unsigned   hold_count = 0;
    int unsigned   quiet_cycles = 0;

    lj126_wall_force_unit #(.DIMENSIONS(DIMS)) u_top (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser, m_tlast);
        if (hold_req && hold_count == 0)
            hold_count <= 400;
        if (hold_count != 0)
        begin
            hold_count <= hold_count - 1;
            m_tready <= 0;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= 18);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_atom(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic last);
        while (!no_idle && $urandom_range(99) < 18)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {pz, py, px};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_atom(px, py, pz, last);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic reg_write(lj126wf_pkg::reg_idx_t idx, logic [63:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, v);
    endtask

    task automatic load_wall(logic [2:0] face, logic [31:0] wp, logic [30:0] cut,
                             lj126wf_pkg::q_t eo, lj126wf_pkg::q_t c1, lj126wf_pkg::q_t c2,
                             lj126wf_pkg::q_t c3, lj126wf_pkg::q_t c4);
        drain();
        reg_write(lj126wf_pkg::REG_WALL_FACE, 64'(face));
        reg_write(lj126wf_pkg::REG_WALL_POS, 64'(wp));
        reg_write(lj126wf_pkg::REG_CUTOFF, 64'(cut));
        reg_write(lj126wf_pkg::REG_E_OFFSET, 64'(eo));
        reg_write(lj126wf_pkg::REG_F_REP, 64'(c1));
        reg_write(lj126wf_pkg::REG_F_ATT, 64'(c2));
        reg_write(lj126wf_pkg::REG_E_REP, 64'(c3));
        reg_write(lj126wf_pkg::REG_E_ATT, 64'(c4));
    endtask

    function automatic lj126wf_pkg::q_t rand_coeff();
        case ($urandom_range(3))
            0: return lj126wf_pkg::q_t'({$urandom, $urandom});
            1: return lj126wf_pkg::q_t'($urandom_range(1 << 28)) - lj126wf_pkg::q_t'(1 << 27);
            2: return $urandom_range(1) ? lj126wf_pkg::QMAX : lj126wf_pkg::QMIN;
            default: return lj126wf_pkg::q_t'($urandom_range(4 << 24));
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        return $urandom;
    endfunction

    task automatic random_atom(int wide);
        logic [31:0] p[3];
        int unsigned axis;
        longint      off, ax_pos;
        axis = board.face >> 1;
        foreach (p[i]) p[i] = rand_pos();
        if (!wide && axis < 3)
        begin
            off = $urandom_range(board.cutoff + 2);
            ax_pos = board.face[0] ? longint'(board.wall_pos) - off
                                   : longint'(board.wall_pos) + off;
            p[axis] = ax_pos[31:0];
        end
        send_atom(p[0], p[1], p[2], $urandom_range(9) == 0);
    endtask

    initial
    begin
        logic [30:0] cut;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset config: cutoff zero, nothing in range
        send_atom(32'h0001_0000, 0, 0, 0);
        send_atom(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1);

        load_wall(3'd0, 32'h0000_0000, 31'h0003_0000, lj126wf_pkg::q_t'(1 << 20),
                  lj126wf_pkg::q_t'(4 << 24), lj126wf_pkg::q_t'(4 << 24),
                  lj126wf_pkg::q_t'(1 << 24), lj126wf_pkg::q_t'(2 << 24));
        send_atom(32'h0000_0000, 0, 0, 0);             // distance zero
        send_atom(32'h0000_0001, 0, 0, 0);             // smallest distance
        send_atom(32'h0001_0000, 0, 0, 0);
        send_atom(32'h0002_FFFF, 0, 0, 0);             // just inside cutoff
        send_atom(32'h0003_0000, 0, 0, 1);             // at cutoff
        send_atom(32'hFFFF_0000, 0, 0, 0);             // behind wall
        send_atom(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_atom(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);

        load_wall(3'd3, 32'h7FFF_FFFF, 31'h7FFF_FFFF, lj126wf_pkg::QMIN, lj126wf_pkg::QMAX,
                  lj126wf_pkg::QMIN, lj126wf_pkg::QMAX, lj126wf_pkg::QMIN);
        send_atom(0, 32'h8000_0000, 0, 0);
        send_atom(0, 32'h7FFF_0000, 0, 0);
        send_atom(0, 32'h7FFF_FFFE, 0, 1);

        load_wall(3'd4, 32'h8000_0000, 31'h7FFF_FFFF, lj126wf_pkg::QMAX, lj126wf_pkg::QMIN,
                  lj126wf_pkg::QMAX, lj126wf_pkg::QMIN, lj126wf_pkg::QMAX);
        send_atom(0, 0, 32'h7FFF_FFFF, 0);
        send_atom(0, 0, 32'h8000_0001, 0);
        send_atom(0, 0, 32'h8001_0000, 1);

        load_wall(3'd5, 32'h0002_0000, 31'h0001_8000, 0,
                  lj126wf_pkg::q_t'(1 << 24), lj126wf_pkg::q_t'(1 << 24),
                  lj126wf_pkg::q_t'(1 << 24), lj126wf_pkg::q_t'(1 << 24));
        send_atom(0, 0, 32'h0001_0000, 0);
        send_atom(0, 0, 32'h0000_C000, 1);

        // invalid axis
        load_wall(3'd6, 0, 31'h0004_0000, 0, lj126wf_pkg::QMAX, 0, lj126wf_pkg::QMAX, 0);
        send_atom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
        load_wall(3'd7, 0, 31'h0004_0000, 0, lj126wf_pkg::QMAX, 0, lj126wf_pkg::QMAX, 0);
        send_atom(0, 0, 32'hFFFF_0000, 1);

        for (int ph = 0; ph < 9; ph++)
        begin
            cut = ($urandom_range(3) == 0) ? 31'h7FFF_FFFF
                                           : 31'($urandom_range(32'h0008_0000, 32'h0000_4000));
            load_wall(3'($urandom_range(7)), $urandom, cut, rand_coeff(),
                      rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
            for (int i = 0; i < 55; i++)
            begin
                if (ph == 2 && i == 0)
                    no_idle = 1;
                if (ph == 3 && i == 0)
                    no_idle = 0;
                if (ph == 4)
                    hold_req = (i == 2);
                random_atom($urandom_range(99) < 20);
            end
        end
        hold_req = 0;
        drain();
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/lj126wf_pkg.sv
hdl/lj126wf_dly.sv
hdl/lj126wf_div.sv
hdl/lj126wf_mulq.sv
hdl/lj126_wall_force_unit.sv
verif/lj126_wall_force_unit_test.sv
